// ===== design/mdisp_pkg.sv =====
// Shared types and constants of the midpoint displacement noise unit.
package mdisp_pkg;

  localparam int unsigned LOG2_SEGMENTS = 5;
  localparam int unsigned NSEG          = 1 << LOG2_SEGMENTS;
  localparam int unsigned NPTS          = NSEG + 1;
  localparam int unsigned IDX_W         = LOG2_SEGMENTS + 1;
  localparam int unsigned LVL_W         = $clog2(LOG2_SEGMENTS + 1);
  localparam int unsigned STACK_CAP     = LOG2_SEGMENTS + 1;
  localparam int unsigned SP_W          = $clog2(STACK_CAP + 1);
  localparam int unsigned VAL_W         = 24;
  localparam int unsigned FRAC_W        = 16;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic signed [VAL_W-1:0] DISP_MIN_RESET = 24'sd0;
  localparam logic signed [VAL_W-1:0] DISP_MAX_RESET = 24'sd25600;

  typedef enum logic {
    MODE_START    = 1'b0,
    MODE_FRACTION = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_IDLE  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISP_MIN = 1'b0,
    CFG_DISP_MAX = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_B,
    ST_CALC,
    ST_WR_LEFT,
    ST_WR_RIGHT
  } state_e;

  typedef struct packed {
    logic                     mode;
    logic signed [VAL_W-1:0]  left_value;
    logic signed [VAL_W-1:0]  right_value;
    logic        [FRAC_W-1:0] random_fraction;
  } in_word_t;

  typedef struct packed {
    logic        [IDX_W-1:0] point_index;
    logic signed [VAL_W-1:0] point_value;
    logic        [1:0]       status;
    logic                    last_point;
  } out_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] first;
    logic [LVL_W-1:0] level;
  } interval_t;

endpackage

// ===== design/midpoint_displacement_1d_unit.sv =====
// Top level of the one-dimensional midpoint displacement noise unit.
//
// This unit builds a midpoint displacement curve over 2^LOG2_SEGMENTS + 1 points in
// signed Q16.8. A start word (mode 0) loads both endpoints and returns two result
// words, point 0 and the last point. Each fraction word (mode 1) fills the next
// midpoint in depth-first order: the mean of its interval's endpoints plus
// (min + fraction/65536 * (max - min)) / 2^level, rounded toward minus infinity and
// saturated. A fraction word with no interval pending returns an idle status; any
// other word seen while min is above max returns a range status and drops the curve.
// Points live in a 33-entry store with one write and one registered read port; the
// pending intervals sit on a small stack of flip-flops. A fraction word that fills a
// midpoint passes ST_READ_B and ST_CALC for the two endpoint reads on the read
// port; a start word passes ST_WR_LEFT and ST_WR_RIGHT for the two endpoint
// writes on the write port; a status-only word leads to ST_IDLE. Results leave
// through a four-word output queue, so words keep coming in while results wait and
// the queue has room. Configuration writes are expected only while the unit is idle.
module midpoint_displacement_1d_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  mdisp_pkg::in_word_t                   in_word_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output mdisp_pkg::out_word_t                  out_word_o,
  input  logic                                  cfg_we_i,
  input  logic [mdisp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mdisp_pkg::VAL_W-1:0]           cfg_data_i
);

  localparam int unsigned IDX_W   = mdisp_pkg::IDX_W;
  localparam int unsigned LVL_W   = mdisp_pkg::LVL_W;
  localparam int unsigned SP_W    = mdisp_pkg::SP_W;
  localparam int unsigned VAL_W   = mdisp_pkg::VAL_W;
  localparam int unsigned FRAC_W  = mdisp_pkg::FRAC_W;
  localparam int unsigned RANGE_W = VAL_W + 1;
  localparam int unsigned PROD_W  = FRAC_W + 1 + RANGE_W;
  localparam int unsigned D_W     = PROD_W + 1;
  // The scaled displacement is shifted by at least 16, so this width holds it
  // together with the endpoint sum.
  localparam int unsigned SUM_W   = D_W - FRAC_W + 1;
  localparam int unsigned SH_W    = $clog2(FRAC_W + mdisp_pkg::LOG2_SEGMENTS + 1);
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FPTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [SUM_W-2:0] SAT_HI = (SUM_W-1)'(8388607);
  localparam logic signed [SUM_W-2:0] SAT_LO = -(SUM_W-1)'(8388608);

  // Configuration registers.
  logic signed [VAL_W-1:0] disp_min_q;
  logic signed [VAL_W-1:0] disp_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_min_q <= mdisp_pkg::DISP_MIN_RESET;
      disp_max_q <= mdisp_pkg::DISP_MAX_RESET;
    end else if (cfg_we_i) begin
      unique case (mdisp_pkg::cfg_idx_e'(cfg_idx_i))
        mdisp_pkg::CFG_DISP_MIN: disp_min_q <= cfg_data_i;
        mdisp_pkg::CFG_DISP_MAX: disp_max_q <= cfg_data_i;
      endcase
    end
  end

  mdisp_pkg::state_e state_q, state_d;

  // Interval stack.
  mdisp_pkg::interval_t stack_q [mdisp_pkg::STACK_CAP];
  mdisp_pkg::interval_t stack_d [mdisp_pkg::STACK_CAP];
  logic [SP_W-1:0]      sp_q, sp_d;

  // Output queue.
  mdisp_pkg::out_word_t fifo_q [FIFO_DEPTH];
  logic [FPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0]    count_q;

  // Work registers of the midpoint in flight.
  logic [FRAC_W-1:0]        frac_q;
  logic [LVL_W-1:0]         lvl_q;
  logic [IDX_W-1:0]         mid_q, last_q;
  logic                     lp_q;
  logic signed [VAL_W-1:0]  a_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [VAL_W-1:0]  left_q, right_q;

  // Store ports.
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr;
  logic [VAL_W-1:0]        ram_wdata, ram_rdata;
  logic                    fwd_q;
  logic [VAL_W-1:0]        fwd_data_q;
  logic signed [VAL_W-1:0] rd_data;

  mdisp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (mdisp_pkg::NPTS)
  ) u_point_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A write and a read of the same entry at one edge return the new data.
  always_ff @(posedge clk_i) begin
    fwd_q      <= ram_we && (ram_waddr == ram_raddr);
    fwd_data_q <= ram_wdata;
  end

  assign rd_data = fwd_q ? fwd_data_q : ram_rdata;

  // Decode of the word at the input.
  logic                 accept, is_start, range_err, has_work, splits;
  logic [SP_W-1:0]      top_idx;
  mdisp_pkg::interval_t top;
  logic [IDX_W-1:0]     half, mid, last_idx;
  logic [SP_W-1:0]      sp_work;
  logic                 ready;

  assign accept    = in_valid_i && !in_stall_o;
  assign is_start  = in_word_i.mode == mdisp_pkg::MODE_START;
  assign range_err = disp_min_q > disp_max_q;
  assign has_work  = sp_q != '0;
  assign top_idx   = has_work ? sp_q - SP_W'(1) : '0;
  assign top       = stack_q[top_idx];
  assign half      = IDX_W'(mdisp_pkg::NSEG) >> top.level;
  assign mid       = top.first + half;
  assign last_idx  = top.first + (half << 1);
  assign splits    = top.level < LVL_W'(mdisp_pkg::LOG2_SEGMENTS);
  assign sp_work   = splits ? sp_q + SP_W'(1) : sp_q - SP_W'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mdisp_pkg::ST_IDLE:     state_d = mdisp_pkg::ST_IDLE;
      mdisp_pkg::ST_READ_B:   state_d = mdisp_pkg::ST_CALC;
      mdisp_pkg::ST_CALC:     state_d = mdisp_pkg::ST_IDLE;
      mdisp_pkg::ST_WR_LEFT:  state_d = mdisp_pkg::ST_WR_RIGHT;
      mdisp_pkg::ST_WR_RIGHT: state_d = mdisp_pkg::ST_IDLE;
      default:                state_d = mdisp_pkg::ST_IDLE;
    endcase
    if (accept) begin
      if (is_start) begin
        state_d = range_err ? mdisp_pkg::ST_IDLE : mdisp_pkg::ST_WR_LEFT;
      end else if (has_work && !range_err) begin
        state_d = mdisp_pkg::ST_READ_B;
      end else begin
        state_d = mdisp_pkg::ST_IDLE;
      end
    end
  end

  // Midpoint arithmetic. The product is registered in ST_READ_B, ahead of the shift,
  // add and saturation in ST_CALC.
  logic signed [RANGE_W-1:0] disp_range;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [D_W-1:0]     disp_full, disp_shift;
  logic [SH_W-1:0]           shift_amt;
  logic signed [SUM_W-1:0]   mid_sum;
  logic signed [SUM_W-2:0]   mid_half;
  logic signed [VAL_W-1:0]   mid_value;

  assign disp_range = {disp_max_q[VAL_W-1], disp_max_q} - {disp_min_q[VAL_W-1], disp_min_q};
  assign prod_d     = $signed({1'b0, frac_q}) * disp_range;
  assign disp_full  = ({{(D_W-VAL_W){disp_min_q[VAL_W-1]}}, disp_min_q} <<< FRAC_W)
                      + {prod_q[PROD_W-1], prod_q};
  assign shift_amt  = SH_W'(FRAC_W - 1) + SH_W'(lvl_q);
  assign disp_shift = disp_full >>> shift_amt;
  assign mid_sum    = {{(SUM_W-VAL_W){a_q[VAL_W-1]}}, a_q}
                      + {{(SUM_W-VAL_W){rd_data[VAL_W-1]}}, rd_data}
                      + disp_shift[SUM_W-1:0];
  assign mid_half   = mid_sum[SUM_W-1:1];

  always_comb begin
    if (mid_half > SAT_HI) begin
      mid_value = SAT_HI[VAL_W-1:0];
    end else if (mid_half < SAT_LO) begin
      mid_value = SAT_LO[VAL_W-1:0];
    end else begin
      mid_value = mid_half[VAL_W-1:0];
    end
  end

  // State outputs: store port control and input readiness.
  logic [FCNT_W:0] room_need;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mid_q;
    ram_wdata = mid_value;
    ram_raddr = top.first;
    ready     = 1'b0;
    unique case (state_q)
      mdisp_pkg::ST_IDLE: begin
        ready = 1'b1;
      end
      mdisp_pkg::ST_READ_B: begin
        ram_raddr = last_q;
      end
      mdisp_pkg::ST_CALC: begin
        ram_we = 1'b1;
        ready  = 1'b1;
      end
      mdisp_pkg::ST_WR_LEFT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = left_q;
      end
      mdisp_pkg::ST_WR_RIGHT: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(mdisp_pkg::NSEG);
        ram_wdata = right_q;
        ready     = 1'b1;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
  end

  // Room for two more results beside the midpoint that may still be in flight.
  assign room_need  = {1'b0, count_q} + (FCNT_W+1)'(state_q == mdisp_pkg::ST_CALC)
                      + (FCNT_W+1)'(2);
  assign in_stall_o = !(ready && (room_need <= (FCNT_W+1)'(FIFO_DEPTH)));

  // Stack update on an accepted word.
  logic lp_d;

  always_comb begin
    stack_d = stack_q;
    sp_d    = sp_q;
    lp_d    = 1'b0;
    if (accept) begin
      if (is_start) begin
        sp_d = '0;
        if (!range_err) begin
          stack_d[0].first = '0;
          stack_d[0].level = LVL_W'(1);
          sp_d             = SP_W'(1);
        end
      end else if (!has_work || range_err) begin
        sp_d = '0;
      end else begin
        sp_d = sp_work;
        lp_d = sp_work == '0;
        if (splits) begin
          // Right half below, left half on top: the left half is done first.
          stack_d[top_idx].first = mid;
          stack_d[top_idx].level = top.level + LVL_W'(1);
          if (sp_q < SP_W'(mdisp_pkg::STACK_CAP)) begin
            stack_d[sp_q].first = top.first;
            stack_d[sp_q].level = top.level + LVL_W'(1);
          end
        end
      end
    end
  end

  // Result words pushed this cycle, oldest first.
  mdisp_pkg::out_word_t push_word [3];
  logic [1:0]           n_push;
  logic                 pop;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      push_word[k] = '0;
    end
    n_push = '0;
    if (state_q == mdisp_pkg::ST_CALC) begin
      push_word[0].point_index = mid_q;
      push_word[0].point_value = mid_value;
      push_word[0].status      = mdisp_pkg::STATUS_OK;
      push_word[0].last_point  = lp_q;
      n_push                   = 2'd1;
    end
    if (accept) begin
      if (is_start && !range_err) begin
        push_word[n_push].point_value          = in_word_i.left_value;
        push_word[n_push].status               = mdisp_pkg::STATUS_OK;
        push_word[n_push + 2'd1].point_index   = IDX_W'(mdisp_pkg::NSEG);
        push_word[n_push + 2'd1].point_value   = in_word_i.right_value;
        push_word[n_push + 2'd1].status        = mdisp_pkg::STATUS_OK;
        n_push                                 = n_push + 2'd2;
      end else if (is_start || (has_work && range_err)) begin
        push_word[n_push].status = mdisp_pkg::STATUS_RANGE;
        n_push                   = n_push + 2'd1;
      end else if (!has_work) begin
        push_word[n_push].status = mdisp_pkg::STATUS_IDLE;
        n_push                   = n_push + 2'd1;
      end
    end
  end

  assign out_valid_o = count_q != '0;
  assign out_word_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mdisp_pkg::ST_IDLE;
      sp_q     <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      sp_q     <= sp_d;
      wr_ptr_q <= wr_ptr_q + FPTR_W'(n_push);
      rd_ptr_q <= rd_ptr_q + FPTR_W'(pop);
      count_q  <= count_q + FCNT_W'(n_push) - FCNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    stack_q <= stack_d;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < n_push) begin
        fifo_q[wr_ptr_q + FPTR_W'(k)] <= push_word[k];
      end
    end
    if (accept) begin
      frac_q  <= in_word_i.random_fraction;
      lvl_q   <= top.level;
      mid_q   <= mid;
      last_q  <= last_idx;
      lp_q    <= lp_d;
      left_q  <= in_word_i.left_value;
      right_q <= in_word_i.right_value;
    end
    if (state_q == mdisp_pkg::ST_READ_B) begin
      a_q    <= rd_data;
      prod_q <= prod_d;
    end
  end

  // The output queue never holds more words than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FCNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  // The stack never grows past its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(mdisp_pkg::STACK_CAP))
    else $error("interval stack overflow");

  // The second endpoint read is always followed by the midpoint write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mdisp_pkg::ST_READ_B) |=> (state_q == mdisp_pkg::ST_CALC))
    else $error("midpoint sequence broken");

  // A midpoint lies strictly inside the curve and is never an endpoint.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mdisp_pkg::ST_CALC) |->
      (mid_q != '0) && (mid_q < IDX_W'(mdisp_pkg::NSEG)))
    else $error("midpoint index out of range");

endmodule

// ===== design/mdisp_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module mdisp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/midpoint_curve_checker.sv =====
// Checker that predicts and compares the point words of the midpoint displacement unit.
module midpoint_curve_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  mdisp_pkg::in_word_t             in_word_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  mdisp_pkg::out_word_t            out_word_i,
  input  logic                            cfg_we_i,
  input  logic [mdisp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mdisp_pkg::VAL_W-1:0]     cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  typedef struct {
    int first;
    int level;
  } span_t;

  localparam longint SAT_HI = 64'sd8388607;
  localparam longint SAT_LO = -64'sd8388608;

  logic signed [mdisp_pkg::VAL_W-1:0] curve_pts [mdisp_pkg::NPTS];
  span_t                              span_stack [mdisp_pkg::STACK_CAP];
  int                                 span_depth = 0;
  logic signed [mdisp_pkg::VAL_W-1:0] disp_lo = mdisp_pkg::DISP_MIN_RESET;
  logic signed [mdisp_pkg::VAL_W-1:0] disp_hi = mdisp_pkg::DISP_MAX_RESET;
  mdisp_pkg::out_word_t               expected_points [$];
  int                                 fail_count = 0;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  function automatic mdisp_pkg::out_word_t point_word(input int idx, input longint val,
                                                      input mdisp_pkg::status_e st,
                                                      input bit last);
    mdisp_pkg::out_word_t w;
    w.point_index = idx[mdisp_pkg::IDX_W-1:0];
    w.point_value = val[mdisp_pkg::VAL_W-1:0];
    w.status      = st;
    w.last_point  = last;
    return w;
  endfunction

  function automatic void push_span(input int first, input int level);
    if (span_depth < mdisp_pkg::STACK_CAP) begin
      span_stack[span_depth].first = first;
      span_stack[span_depth].level = level;
      span_depth++;
    end
  endfunction

  // Works out the point words that one accepted word causes and updates the curve state.
  function automatic void predict_points(input mdisp_pkg::in_word_t w);
    span_t  top;
    int     len;
    int     half;
    int     mid;
    longint a;
    longint b;
    longint d;
    longint t;
    longint v;
    if (w.mode == mdisp_pkg::MODE_START) begin
      span_depth = 0;
      if (disp_lo > disp_hi) begin
        expected_points.push_back(point_word(0, 0, mdisp_pkg::STATUS_RANGE, 1'b0));
        return;
      end
      curve_pts[0] = w.left_value;
      curve_pts[mdisp_pkg::NSEG] = w.right_value;
      push_span(0, 1);
      expected_points.push_back(point_word(0, w.left_value, mdisp_pkg::STATUS_OK, 1'b0));
      expected_points.push_back(point_word(mdisp_pkg::NSEG, w.right_value,
                                           mdisp_pkg::STATUS_OK, 1'b0));
      return;
    end
    if (span_depth == 0) begin
      expected_points.push_back(point_word(0, 0, mdisp_pkg::STATUS_IDLE, 1'b0));
      return;
    end
    if (disp_lo > disp_hi) begin
      span_depth = 0;
      expected_points.push_back(point_word(0, 0, mdisp_pkg::STATUS_RANGE, 1'b0));
      return;
    end
    span_depth--;
    top  = span_stack[span_depth];
    len  = mdisp_pkg::NSEG >> (top.level - 1);
    half = len >> 1;
    mid  = top.first + half;
    a    = longint'(curve_pts[top.first]);
    b    = longint'(curve_pts[top.first + len]);
    d    = longint'(disp_lo) * 65536
         + longint'(w.random_fraction) * (longint'(disp_hi) - longint'(disp_lo));
    t    = (a + b) * (longint'(1) << (15 + top.level)) + d;
    // An arithmetic shift of a signed value rounds toward minus infinity.
    v    = t >>> (16 + top.level);
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    curve_pts[mid] = v[mdisp_pkg::VAL_W-1:0];
    if (half > 1) begin
      push_span(mid, top.level + 1);
      push_span(top.first, top.level + 1);
    end
    expected_points.push_back(point_word(mid, v, mdisp_pkg::STATUS_OK, span_depth == 0));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mdisp_pkg::out_word_t want;
    if (!rst_ni) begin
      span_depth = 0;
      disp_lo    = mdisp_pkg::DISP_MIN_RESET;
      disp_hi    = mdisp_pkg::DISP_MAX_RESET;
      expected_points.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          report_mismatch("point word arrived with none expected");
        end else begin
          want = expected_points.pop_front();
          if (out_word_i.point_index !== want.point_index)
            report_mismatch($sformatf("point_index got %0d, expected %0d",
                                      out_word_i.point_index, want.point_index));
          if (out_word_i.point_value !== want.point_value)
            report_mismatch($sformatf("point_value at %0d got %0d, expected %0d",
                                      want.point_index, out_word_i.point_value,
                                      want.point_value));
          if (out_word_i.status !== want.status)
            report_mismatch($sformatf("status got %0d, expected %0d",
                                      out_word_i.status, want.status));
          if (out_word_i.last_point !== want.last_point)
            report_mismatch($sformatf("last_point at %0d got %0d, expected %0d",
                                      want.point_index, out_word_i.last_point,
                                      want.last_point));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mdisp_pkg::CFG_DISP_MIN: disp_lo = cfg_data_i;
          mdisp_pkg::CFG_DISP_MAX: disp_hi = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_points(in_word_i);
    end
    pending_o = expected_points.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the simulation: clock, reset, stimulus and verdict for the midpoint displacement unit.
module testbench;

  // Cycles without any handshake on either channel before the run is declared hung.
  // The longest legal quiet stretch is the deliberate receiver hold-off.
  localparam int HANG_LIMIT = 5000;
  // Word count at which the receiver starts its long hold-off.
  localparam int HOLD_AT    = 700;
  localparam int HOLD_LEN   = 300;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  mdisp_pkg::in_word_t             in_word;
  logic                            out_valid;
  logic                            out_stall;
  mdisp_pkg::out_word_t            out_word;
  logic                            cfg_we;
  logic [mdisp_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [mdisp_pkg::VAL_W-1:0]     cfg_data;
  int                              fail_count;
  int                              pending;

  // Shared between the stimulus and the receiver: no_idle turns off random gaps and stalls
  // on both sides, words_sent lets the receiver pick the moment for its long hold-off.
  bit no_idle    = 1'b0;
  int words_sent = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  int quiet_cycles = 0;

  midpoint_displacement_1d_unit u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  midpoint_curve_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A start word carries its endpoints; the fraction field is ignored, so it gets noise.
  function automatic mdisp_pkg::in_word_t start_word(input logic [23:0] left,
                                                     input logic [23:0] right);
    mdisp_pkg::in_word_t w;
    w.mode            = mdisp_pkg::MODE_START;
    w.left_value      = left;
    w.right_value     = right;
    w.random_fraction = 16'($urandom);
    return w;
  endfunction

  // A fraction word carries one random fraction; the endpoint fields are ignored noise.
  function automatic mdisp_pkg::in_word_t fraction_word(input logic [15:0] frac);
    mdisp_pkg::in_word_t w;
    w.mode            = mdisp_pkg::MODE_FRACTION;
    w.left_value      = 24'($urandom);
    w.right_value     = 24'($urandom);
    w.random_fraction = frac;
    return w;
  endfunction

  // Endpoints are mostly full-range values, sometimes small ones near zero.
  function automatic logic [23:0] random_endpoint();
    int small_val;
    small_val = int'($urandom_range(2047)) - 1024;
    if ($urandom_range(3) == 0) return small_val[23:0];
    return 24'($urandom);
  endfunction

  function automatic logic [15:0] random_fraction();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one word, with a random gap before it, and holds it until it is taken.
  task automatic send_word(input mdisp_pkg::in_word_t w);
    while (!no_idle && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Lets every expected point word drain, then waits for the unit to settle.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes both displacement bounds back to back, the minimum first.
  task automatic set_range(input logic [23:0] lo, input logic [23:0] hi);
    cfg_we   <= 1'b1;
    cfg_idx  <= mdisp_pkg::CFG_DISP_MIN;
    cfg_data <= lo;
    @(posedge clk);
    cfg_idx  <= mdisp_pkg::CFG_DISP_MAX;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Random but ordered bounds, so that curves actually get generated.
  task automatic set_random_range();
    logic signed [23:0] x;
    logic signed [23:0] y;
    x = 24'($urandom);
    y = 24'($urandom);
    if (x > y) set_range(y, x);
    else set_range(x, y);
  endtask

  // Mostly whole curves: a start and the 31 fractions that fill it. Some curves are cut
  // short by the next start, and some run past the end so that idle words show up.
  task automatic run_curves(input int count);
    int n;
    int fracs;
    n = 0;
    while (n < count) begin
      send_word(start_word(random_endpoint(), random_endpoint()));
      n++;
      fracs = ($urandom_range(9) < 7) ? mdisp_pkg::NSEG - 1 : $urandom_range(40);
      for (int k = 0; k < fracs; k++) begin
        send_word(fraction_word(random_fraction()));
        n++;
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off once enough words have gone in, so
  // that the output queue fills and the unit has to stall its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && words_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 31);
      end
    end
  end

  // Watchdog: any handshake restarts the count of quiet cycles.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = mdisp_pkg::CFG_DISP_MIN;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the widest displacement range. A fraction with nothing pending
    // comes first, then curves whose endpoints sit at the extremes so that both
    // saturation limits are hit, with fractions at both ends of their range.
    set_range(24'h800000, 24'h7FFFFF);
    send_word(fraction_word(16'hFFFF));
    send_word(start_word(24'h800000, 24'h7FFFFF));
    send_word(fraction_word(16'h0000));
    send_word(fraction_word(16'hFFFF));
    send_word(fraction_word(16'h0000));
    send_word(fraction_word(16'hFFFF));
    send_word(fraction_word(16'h8000));
    send_word(start_word(24'h7FFFFF, 24'h7FFFFF));
    send_word(fraction_word(16'hFFFF));
    send_word(fraction_word(16'hFFFF));
    send_word(fraction_word(16'hFFFF));
    send_word(start_word(24'h800000, 24'h800000));
    send_word(fraction_word(16'h0000));
    send_word(fraction_word(16'h0000));

    // Min above max while a curve is still pending: the next fraction aborts the curve,
    // the one after finds nothing pending, and a start is refused outright.
    wait_quiet();
    set_range(24'd100, -24'sd100);
    send_word(fraction_word(16'h1234));
    send_word(fraction_word(16'h4321));
    send_word(start_word(24'h000100, 24'hFFFF00));

    // Equal bounds: the displacement no longer depends on the fraction.
    wait_quiet();
    set_range(24'd5, 24'd5);
    send_word(start_word(random_endpoint(), random_endpoint()));
    for (int k = 0; k < 4; k++) send_word(fraction_word(random_fraction()));

    // Random part, phase by phase with the bounds changed only while the unit is idle.
    wait_quiet();
    set_range(mdisp_pkg::DISP_MIN_RESET, mdisp_pkg::DISP_MAX_RESET);
    run_curves(320);

    // A stretch with no gaps and no stalls at all, at the widest range.
    wait_quiet();
    no_idle = 1'b1;
    set_range(24'h800000, 24'h7FFFFF);
    run_curves(320);
    no_idle = 1'b0;

    wait_quiet();
    set_range(-24'sd256, 24'sd256);
    run_curves(320);

    wait_quiet();
    set_random_range();
    run_curves(320);

    // Broken bounds: each start answers with a range status, each fraction with an idle one.
    wait_quiet();
    set_range(24'd1000, -24'sd1000);
    run_curves(40);

    wait_quiet();
    set_range(24'h7FFFFF, 24'h7FFFFF);
    run_curves(200);

    wait_quiet();
    set_random_range();
    run_curves(320);

    wait_quiet();
    set_range(24'h800000, 24'h800000);
    run_curves(160);

    wait_quiet();
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mdisp_pkg.sv
design/mdisp_ram.sv
design/midpoint_displacement_1d_unit.sv
sim/midpoint_curve_checker.sv
sim/testbench.sv
